// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the event merger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked at every clock, off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/mtem_pkg.sv =====
// Package: modes, status codes, state encoding and default sizes of the event merger.
package mtem_pkg;

    localparam int TRACKS_DEF    = 16;
    localparam int EPT_DEF       = 1024;
    localparam int TIME_BITS_DEF = 28;

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_REWIND = 3'd1;
    localparam logic [2:0] MODE_GET    = 3'd2;
    localparam logic [2:0] MODE_PEEK   = 3'd3;
    localparam logic [2:0] MODE_SEEK   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_ORDER   = 2'd2;
    localparam logic [1:0] ST_NO_MORE = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_FIND = 8'b0000_0100,
        S_READ = 8'b0000_1000,
        S_DATA = 8'b0001_0000,
        S_SONG = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

endpackage

// ===== rtl/core/multi_track_event_merger.sv =====
// Multi-track event merger: event memory, per-track heads and merge sequencer.

// Each item is handled alone, one at a time. Load and rewind walk the tracks in
// use once to find the song length; peek, get and seek walk them first to find
// the earliest head and again for the song length, seek repeating the search for
// each event it skips. The tracks are walked one a cycle, and each event read
// goes through the event memory, which has a registered read. Rewind updates all
// track heads together from stored first times. A finished result waits in an
// output register while the next item is taken.
`include "assert_macros.svh"

module multi_track_event_merger #(
    parameter int TRACKS           = mtem_pkg::TRACKS_DEF,
    parameter int EVENTS_PER_TRACK = mtem_pkg::EPT_DEF,
    parameter int TIME_BITS        = mtem_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [3:0]  track_index,
    input  logic [27:0] event_time,
    input  logic [23:0] event_bytes,
    input  logic [1:0]  event_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [3:0]  track_out,
    output logic [9:0]  event_pos,
    output logic [27:0] time_out,
    output logic [27:0] delta_out,
    output logic [23:0] bytes_out,
    output logic [1:0]  length_out,
    output logic [1:0]  status,
    output logic [27:0] song_length
);
    import mtem_pkg::*;

    localparam int TW  = $clog2(TRACKS);
    localparam int NW  = TW + 1;
    localparam int CW  = $clog2(EVENTS_PER_TRACK + 1);
    localparam int AW  = $clog2(TRACKS * EVENTS_PER_TRACK);
    localparam int TB  = TIME_BITS;
    localparam int SW  = TB + 26;
    localparam int DEPTH = TRACKS * EVENTS_PER_TRACK;
    localparam logic [AW:0] EPT_A = (AW + 1)'(EVENTS_PER_TRACK);

    // event memory: time, bytes, length per slot
    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rdata_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    // per-track heads
    logic [CW-1:0] count_reg [TRACKS];
    logic [CW-1:0] ptr_reg   [TRACKS];
    logic          done_reg  [TRACKS];
    logic [TB-1:0] next_reg  [TRACKS];
    logic [TB-1:0] last_reg  [TRACKS];
    logic [TB-1:0] first_reg [TRACKS];
    logic [TB-1:0] prev_reg  [TRACKS];

    state_t        state_reg;
    logic [4:0]    tiu_reg;
    logic [2:0]    mode_reg;
    logic [3:0]    trk_in_reg;
    logic [TB-1:0] tm_reg;
    logic [23:0]   by_reg;
    logic [1:0]    ln_reg;
    logic [TW-1:0] walk_reg;
    logic          bv_reg;
    logic [TW-1:0] bi_reg;
    logic [TB-1:0] bt_reg;
    logic [TW-1:0] best_reg;
    logic          adv_reg;
    logic [TB-1:0] song_reg;

    // pending result
    logic          r_found_reg;
    logic [3:0]    r_trk_reg;
    logic [9:0]    r_num_reg;
    logic [27:0]   r_time_reg;
    logic [27:0]   r_delta_reg;
    logic [23:0]   r_bytes_reg;
    logic [1:0]    r_len_reg;
    logic [1:0]    r_stat_reg;

    // output register
    logic          out_valid_reg;
    logic          found_reg;
    logic [3:0]    track_out_reg;
    logic [9:0]    event_pos_reg;
    logic [27:0]   time_out_reg;
    logic [27:0]   delta_out_reg;
    logic [23:0]   bytes_out_reg;
    logic [1:0]    length_out_reg;
    logic [1:0]    status_reg;
    logic [27:0]   song_length_reg;

    // active track count
    logic [NW-1:0] n_act;
    always_comb
    begin
        if (tiu_reg == 5'd0)
            n_act = NW'(1);
        else if (32'(tiu_reg) > TRACKS)
            n_act = NW'(TRACKS);
        else
            n_act = NW'(tiu_reg);
    end

    logic walk_last;
    assign walk_last = ((NW'(walk_reg) + NW'(1)) == n_act);

    // load decode
    logic [TW-1:0] tr_idx;
    logic [TB-1:0] tm_in;
    logic [31:0]   tm_wide;
    assign tr_idx  = TW'(trk_in_reg);
    assign tm_wide = 32'(event_time);
    assign tm_in   = tm_wide[TB-1:0];

    // single selected track for all head reads
    logic [TW-1:0] sel;
    always_comb
    begin
        unique case (state_reg) inside
            S_EXEC:         sel = tr_idx;
            S_FIND, S_SONG: sel = walk_reg;
            default:        sel = best_reg;
        endcase
    end

    logic [CW-1:0] sel_count;
    logic [CW-1:0] sel_ptr;
    logic          sel_done;
    logic [TB-1:0] sel_next;
    logic [TB-1:0] sel_last;
    logic [TB-1:0] sel_prev;
    assign sel_count = count_reg[sel];
    assign sel_ptr   = ptr_reg[sel];
    assign sel_done  = done_reg[sel];
    assign sel_next  = next_reg[sel];
    assign sel_last  = last_reg[sel];
    assign sel_prev  = prev_reg[sel];

    logic [AW:0] base_addr;
    assign base_addr = (AW + 1)'(sel) * EPT_A;

    // load checks
    logic ld_bad_trk;
    logic ld_full;
    logic ld_order;
    assign ld_bad_trk = (32'(trk_in_reg) >= TRACKS);
    assign ld_full    = ld_bad_trk || (32'(sel_count) >= EVENTS_PER_TRACK);
    assign ld_order   = (sel_count != '0) && (tm_reg < sel_last);

    // load outcome
    logic       ld_ok;
    logic [1:0] ld_stat;
    always_comb
    begin
        ld_ok   = 1'b0;
        ld_stat = ST_OK;
        if (mode_reg == MODE_LOAD)
        begin
            if (ld_full)
                ld_stat = ST_FULL;
            else if (ld_order)
                ld_stat = ST_ORDER;
            else
                ld_ok = 1'b1;
        end
    end

    // minimum search step
    logic          f_bv;
    logic [TW-1:0] f_bi;
    logic [TB-1:0] f_bt;
    always_comb
    begin
        f_bv = bv_reg;
        f_bi = bi_reg;
        f_bt = bt_reg;
        if (!sel_done && (!bv_reg || sel_next < bt_reg))
        begin
            f_bv = 1'b1;
            f_bi = walk_reg;
            f_bt = sel_next;
        end
    end

    // slot read data
    logic [TB-1:0] rd_time;
    logic [23:0]   rd_bytes;
    logic [1:0]    rd_len;
    assign rd_time  = rdata_reg[SW-1:26];
    assign rd_bytes = rdata_reg[25:2];
    assign rd_len   = rdata_reg[1:0];

    logic [CW-1:0] ptr_p1;
    assign ptr_p1 = sel_ptr + CW'(1);

    // widening helpers for fixed-width outputs
    logic [TB-1:0] ld_delta;
    logic [TB-1:0] em_delta;
    logic [31:0]   w_tm;
    logic [31:0]   w_ld_delta;
    logic [31:0]   w_rd_time;
    logic [31:0]   w_em_delta;
    logic [31:0]   w_song;
    logic [31:0]   w_cnt;
    logic [31:0]   w_ptr;
    logic [31:0]   w_best;
    assign ld_delta   = (sel_count != '0) ? (tm_reg - sel_last) : tm_reg;
    assign em_delta   = rd_time - sel_prev;
    assign w_tm       = 32'(tm_reg);
    assign w_ld_delta = 32'(ld_delta);
    assign w_rd_time  = 32'(rd_time);
    assign w_em_delta = 32'(em_delta);
    assign w_song     = 32'(song_reg);
    assign w_cnt      = 32'(sel_count);
    assign w_ptr      = 32'(sel_ptr);
    assign w_best     = 32'(best_reg);

    // memory port control
    always_comb
    begin
        wr_en   = (state_reg == S_EXEC) && ld_ok;
        wr_addr = AW'(base_addr + (AW + 1)'(sel_count));
        wr_data = {tm_reg, by_reg, ln_reg};
        rd_en   = (state_reg == S_READ);
        rd_addr = AW'(base_addr + (AW + 1)'(adv_reg ? ptr_p1 : sel_ptr));
    end

    // event memory, write then registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign in_ready = (state_reg == S_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tiu_reg       <= 5'd1;
            out_valid_reg <= 1'b0;
            walk_reg      <= '0;
            bv_reg        <= 1'b0;
            adv_reg       <= 1'b0;
            for (int t = 0; t < TRACKS; t++)
            begin
                count_reg[t] <= '0;
                ptr_reg[t]   <= '0;
                done_reg[t]  <= 1'b1;
                next_reg[t]  <= '0;
                last_reg[t]  <= '0;
                first_reg[t] <= '0;
                prev_reg[t]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                tiu_reg <= cfg_wdata;
            // S_OUT handles the output register itself
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg   <= mode;
                        trk_in_reg <= track_index;
                        tm_reg     <= tm_in;
                        by_reg     <= event_bytes;
                        ln_reg     <= event_length;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    r_found_reg <= ld_ok;
                    r_trk_reg   <= (mode_reg == MODE_LOAD) ? trk_in_reg : 4'd0;
                    r_num_reg   <= ld_ok ? w_cnt[9:0] : 10'd0;
                    r_time_reg  <= ld_ok ? w_tm[27:0] : 28'd0;
                    r_delta_reg <= ld_ok ? w_ld_delta[27:0] : 28'd0;
                    r_bytes_reg <= ld_ok ? by_reg : 24'd0;
                    r_len_reg   <= ld_ok ? ln_reg : 2'd0;
                    r_stat_reg  <= ld_stat;
                    walk_reg    <= '0;
                    bv_reg      <= 1'b0;
                    adv_reg     <= 1'b0;
                    song_reg    <= '0;
                    if (mode_reg == MODE_GET || mode_reg == MODE_PEEK ||
                        mode_reg == MODE_SEEK)
                        state_reg <= S_FIND;
                    else
                        state_reg <= S_SONG;
                    // rewind, also the first step of a seek
                    if (mode_reg == MODE_REWIND || mode_reg == MODE_SEEK)
                    begin
                        for (int t = 0; t < TRACKS; t++)
                        begin
                            ptr_reg[t]  <= '0;
                            prev_reg[t] <= '0;
                            done_reg[t] <= (count_reg[t] == '0);
                            next_reg[t] <= (count_reg[t] == '0) ? '0 : first_reg[t];
                        end
                    end
                    // append an accepted load
                    if (ld_ok)
                    begin
                        count_reg[sel] <= sel_count + CW'(1);
                        last_reg[sel]  <= tm_reg;
                        if (sel_count == '0)
                        begin
                            first_reg[sel] <= tm_reg;
                            ptr_reg[sel]   <= '0;
                            prev_reg[sel]  <= '0;
                            done_reg[sel]  <= 1'b0;
                            next_reg[sel]  <= tm_reg;
                        end
                    end
                end
                S_FIND:
                begin
                    bi_reg <= f_bi;
                    bt_reg <= f_bt;
                    if (walk_last)
                    begin
                        walk_reg <= '0;
                        bv_reg   <= 1'b0;
                        if (!f_bv)
                        begin
                            r_stat_reg <= ST_NO_MORE;
                            song_reg   <= '0;
                            state_reg  <= S_SONG;
                        end
                        else
                        begin
                            best_reg  <= f_bi;
                            adv_reg   <= (mode_reg == MODE_SEEK) && (f_bt < tm_reg);
                            state_reg <= S_READ;
                        end
                    end
                    else
                    begin
                        bv_reg   <= f_bv;
                        walk_reg <= walk_reg + TW'(1);
                    end
                end
                S_READ:
                    state_reg <= S_DATA;
                S_DATA:
                begin
                    if (adv_reg)
                    begin
                        // step the track past its head
                        ptr_reg[sel]  <= ptr_p1;
                        prev_reg[sel] <= sel_next;
                        if (ptr_p1 >= sel_count)
                            done_reg[sel] <= 1'b1;
                        else
                            next_reg[sel] <= rd_time;
                        adv_reg   <= 1'b0;
                        walk_reg  <= '0;
                        song_reg  <= '0;
                        state_reg <= (mode_reg == MODE_SEEK) ? S_FIND : S_SONG;
                    end
                    else
                    begin
                        r_found_reg <= 1'b1;
                        r_trk_reg   <= w_best[3:0];
                        r_num_reg   <= w_ptr[9:0];
                        r_time_reg  <= w_rd_time[27:0];
                        r_delta_reg <= w_em_delta[27:0];
                        r_bytes_reg <= rd_bytes;
                        r_len_reg   <= rd_len;
                        walk_reg    <= '0;
                        song_reg    <= '0;
                        if (mode_reg == MODE_GET)
                        begin
                            adv_reg   <= 1'b1;
                            state_reg <= S_READ;
                        end
                        else
                            state_reg <= S_SONG;
                    end
                end
                S_SONG:
                begin
                    // latest last time over tracks in use
                    if (sel_count != '0 && sel_last > song_reg)
                        song_reg <= sel_last;
                    if (walk_last)
                    begin
                        walk_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        walk_reg <= walk_reg + TW'(1);
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        found_reg        <= r_found_reg;
                        track_out_reg    <= r_trk_reg;
                        event_pos_reg    <= r_num_reg;
                        time_out_reg     <= r_time_reg;
                        delta_out_reg    <= r_delta_reg;
                        bytes_out_reg    <= r_bytes_reg;
                        length_out_reg   <= r_len_reg;
                        status_reg       <= r_stat_reg;
                        song_length_reg  <= w_song[27:0];
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign track_out    = track_out_reg;
    assign event_pos    = event_pos_reg;
    assign time_out     = time_out_reg;
    assign delta_out    = delta_out_reg;
    assign bytes_out    = bytes_out_reg;
    assign length_out   = length_out_reg;
    assign status       = status_reg;
    assign song_length  = song_length_reg;

    // checks
    logic none_zero;
    assign none_zero = (time_out == 28'd0) && (bytes_out == 24'd0) && (length_out == 2'd0);

    `ASSERT_NEVER(a_found_ok, clk, rst_n, out_valid && found && status != ST_OK)
    `ASSERT_CLK(a_none_zero, clk, rst_n, (out_valid && !found) |-> none_zero)
    `ASSERT_CLK(a_accept_exec, clk, rst_n, (in_valid && in_ready) |=> (state_reg == S_EXEC))
    `ASSERT_NEVER(a_write_state, clk, rst_n, wr_en && state_reg != S_EXEC)

endmodule
